FILE: rtl/otacc_pkg.sv
// ----------------------------------------------------------------------------
// otacc_pkg
// Shared types, constants and helpers for the outer-product tile accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package otacc_pkg;

  // tile shape, each in 1..4
  localparam int unsigned TILE_ROWS = 4;
  localparam int unsigned TILE_COLS = 4;

  // number of A and B lanes that the input transaction carries
  localparam int unsigned LANES = 4;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TILE_ROWS - 1);
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(TILE_COLS - 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [ACC_W:0]    sum_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             accum;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } status_t;

  // clamp a one-bit-wider sum to the accumulator range
  function automatic acc_t sat_acc(sum_t s);
    acc_t r;
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/otacc_if.sv
// ----------------------------------------------------------------------------
// otacc interfaces
// Valid/ready channels for k-step input and tile result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface otacc_step_if;
  logic                 valid;
  logic                 ready;
  otacc_pkg::elem_t     a_row0;
  otacc_pkg::elem_t     a_row1;
  otacc_pkg::elem_t     a_row2;
  otacc_pkg::elem_t     a_row3;
  otacc_pkg::elem_t     b_col0;
  otacc_pkg::elem_t     b_col1;
  otacc_pkg::elem_t     b_col2;
  otacc_pkg::elem_t     b_col3;
  logic                 first_step;
  logic                 last_step;

  modport source (
    output valid, a_row0, a_row1, a_row2, a_row3,
           b_col0, b_col1, b_col2, b_col3, first_step, last_step,
    input  ready
  );
  modport sink (
    input  valid, a_row0, a_row1, a_row2, a_row3,
           b_col0, b_col1, b_col2, b_col3, first_step, last_step,
    output ready
  );
endinterface

interface otacc_result_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           acc_row;
  logic [1:0]           tile_col;
  otacc_pkg::acc_t      sum_value;
  logic                 tile_done;

  modport source (
    output valid, acc_row, tile_col, sum_value, tile_done,
    input  ready
  );
  modport sink (
    input  valid, acc_row, tile_col, sum_value, tile_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/otacc_ctrl.sv
// ----------------------------------------------------------------------------
// otacc_ctrl
// Sequencer: takes a step, runs the accumulate cycle, then walks the drain after a last step.
// ----------------------------------------------------------------------------
`default_nettype none

module otacc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_valid,
  output      logic               step_ready,
  output      logic               result_valid,
  input  wire logic               result_ready,
  output      logic               result_done,
  output      otacc_pkg::cmd_t    cmd,
  input  wire otacc_pkg::status_t status
);

  otacc_pkg::state_t state, state_next;
  logic [otacc_pkg::IDX_W-1:0] row, row_next;
  logic [otacc_pkg::IDX_W-1:0] col, col_next;
  logic at_end;
  logic out_fire;

  assign at_end   = (row == otacc_pkg::LAST_ROW) && (col == otacc_pkg::LAST_COL);
  assign out_fire = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= otacc_pkg::ST_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    case (state)
      otacc_pkg::ST_IDLE: begin
        if (step_valid) begin
          state_next = otacc_pkg::ST_ACC;
        end
      end
      otacc_pkg::ST_ACC: begin
        row_next = '0;
        col_next = '0;
        state_next = status.last ? otacc_pkg::ST_DRAIN : otacc_pkg::ST_IDLE;
      end
      otacc_pkg::ST_DRAIN: begin
        if (out_fire) begin
          if (at_end) begin
            state_next = otacc_pkg::ST_IDLE;
          end else if (col == otacc_pkg::LAST_COL) begin
            col_next = '0;
            row_next = row + 1'b1;
          end else begin
            col_next = col + 1'b1;
          end
        end
      end
      default: begin
        state_next = otacc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    step_ready   = 1'b0;
    result_valid = 1'b0;
    result_done  = 1'b0;
    cmd.load     = 1'b0;
    cmd.accum    = 1'b0;
    cmd.row      = row;
    cmd.col      = col;
    case (state)
      otacc_pkg::ST_IDLE: begin
        step_ready = 1'b1;
        cmd.load   = step_valid;
      end
      otacc_pkg::ST_ACC: begin
        cmd.accum = 1'b1;
      end
      otacc_pkg::ST_DRAIN: begin
        result_valid = 1'b1;
        result_done  = at_end;
      end
      default: begin
        step_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/otacc_dp.sv
// ----------------------------------------------------------------------------
// otacc_dp
// Product registers, saturating 48-bit accumulator array and drain select.
// ----------------------------------------------------------------------------
`default_nettype none

module otacc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire otacc_pkg::cmd_t     cmd,
  output      otacc_pkg::status_t  status,
  input  wire otacc_pkg::elem_t    a_vec [otacc_pkg::LANES],
  input  wire otacc_pkg::elem_t    b_vec [otacc_pkg::LANES],
  input  wire logic                first_step,
  input  wire logic                last_step,
  output      otacc_pkg::acc_t     sum_value
);

  otacc_pkg::prod_t prod [otacc_pkg::TILE_ROWS][otacc_pkg::TILE_COLS];
  otacc_pkg::acc_t  acc  [otacc_pkg::TILE_ROWS][otacc_pkg::TILE_COLS];
  logic first_q;
  logic last_q;

  assign status.last = last_q;

  // one multiplier per tile position, loaded with the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
        for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
          prod[r][c] <= a_vec[r] * b_vec[c];
        end
      end
      first_q <= first_step;
      last_q  <= last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
        for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
          acc[r][c] <= '0;
        end
      end
    end else if (cmd.accum) begin
      for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
        for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
          // first step starts the tile from zero
          acc[r][c] <= otacc_pkg::sat_acc(
            (first_q ? '0 : {acc[r][c][otacc_pkg::ACC_W-1], acc[r][c]})
            + {{(otacc_pkg::ACC_W + 1 - otacc_pkg::PROD_W){prod[r][c][otacc_pkg::PROD_W-1]}},
               prod[r][c]});
        end
      end
    end
  end

  // drain select, and-or over the fixed registers
  always_comb begin
    sum_value = '0;
    for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
      for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
        if ((cmd.row == otacc_pkg::IDX_W'(r)) && (cmd.col == otacc_pkg::IDX_W'(c))) begin
          sum_value = sum_value | acc[r][c];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/outer_product_tile_accumulator.sv
// ----------------------------------------------------------------------------
// outer_product_tile_accumulator
// 4x4 outer-product tile engine, C += A^T * B, Q4.12 in, Q24.24 out.
// ----------------------------------------------------------------------------
// In a k-step transaction the accept cycle loads sixteen product registers
// and the next updates all sixteen saturating accumulators; no new step is
// taken until that update is done. A step marked last_step then drains
// the tile in row-major order at one result per cycle while the result
// side is ready; no new step is taken until the sixteenth result, flagged
// tile_done, has gone out. The accumulators reset to zero and keep their
// values after a drain.
// ----------------------------------------------------------------------------
`default_nettype none

module outer_product_tile_accumulator (
  input  wire logic       clk,
  input  wire logic       rst,
  otacc_step_if.sink      step,
  otacc_result_if.source  result
);

  otacc_pkg::cmd_t    cmd;
  otacc_pkg::status_t status;
  otacc_pkg::elem_t   a_vec [otacc_pkg::LANES];
  otacc_pkg::elem_t   b_vec [otacc_pkg::LANES];

  assign a_vec[0] = step.a_row0;
  assign a_vec[1] = step.a_row1;
  assign a_vec[2] = step.a_row2;
  assign a_vec[3] = step.a_row3;
  assign b_vec[0] = step.b_col0;
  assign b_vec[1] = step.b_col1;
  assign b_vec[2] = step.b_col2;
  assign b_vec[3] = step.b_col3;

  otacc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step.valid),
    .step_ready   (step.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_done  (result.tile_done),
    .cmd          (cmd),
    .status       (status)
  );

  otacc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .a_vec      (a_vec),
    .b_vec      (b_vec),
    .first_step (step.first_step),
    .last_step  (step.last_step),
    .sum_value  (result.sum_value)
  );

  assign result.acc_row  = cmd.row;
  assign result.tile_col = cmd.col;

endmodule

`default_nettype wire

FILE: rtl/otacc_chk.sv
// ----------------------------------------------------------------------------
// otacc_chk
// Port-level checks on step intake and tile drain ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module otacc_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       step_valid,
  input wire logic       step_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic [1:0] acc_row,
  input wire logic [1:0] tile_col,
  input wire logic       tile_done
);

  // no intake while a tile is draining
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(step_ready && result_valid))
    else $error("step ready during drain");

  // a step transaction is followed by the accumulate cycle
  a_step_gap: assert property (@(posedge clk) disable iff (rst)
    (step_valid && step_ready) |=> !step_ready && !result_valid)
    else $error("no accumulate cycle after step");

  // the drain runs without gaps until the final result
  a_drain_cont: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !tile_done) |=> result_valid)
    else $error("drain broke off early");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && tile_done) |=> !result_valid)
    else $error("result after tile_done");

  // stalled result keeps its position
  a_hold_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(acc_row) && $stable(tile_col))
    else $error("result position changed under stall");

endmodule

bind outer_product_tile_accumulator otacc_chk u_otacc_chk (
  .clk          (clk),
  .rst          (rst),
  .step_valid   (step.valid),
  .step_ready   (step.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .acc_row      (result.acc_row),
  .tile_col     (result.tile_col),
  .tile_done    (result.tile_done)
);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the outer-product tile accumulator. A queue-fed
// driver sends k-step transactions and a monitor predicts the sixteen
// saturating accumulators. Every drained result is checked in row-major order
// against the prediction, under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int PHASE_STEPS = 120;
  localparam longint ACC_HI  = (longint'(1) <<< 47) - 1;
  localparam longint ACC_LO  = -(longint'(1) <<< 47);

  typedef struct packed {
    logic                        hold;
    logic                        first;
    logic                        last;
    otacc_pkg::elem_t [3:0]      a;
    otacc_pkg::elem_t [3:0]      b;
  } kstep_t;

  typedef struct packed {
    logic [1:0]      row;
    logic [1:0]      col;
    otacc_pkg::acc_t sum;
    logic            done;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  otacc_step_if   step_ch ();
  otacc_result_if res_ch ();

  outer_product_tile_accumulator uut (
    .clk    (clk),
    .rst    (rst),
    .step   (step_ch),
    .result (res_ch)
  );

  kstep_t       pending_ksteps[$];
  tile_result_t expected_sums[$];
  longint       tile_acc [otacc_pkg::TILE_ROWS][otacc_pkg::TILE_COLS];

  kstep_t      drive_step;
  kstep_t      taken_step;
  logic        step_fire;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          steps_pushed;
  int          steps_taken;
  int          tiles_drained;
  int          results_checked;
  int          fault_count;
  int          mismatch_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    step_ch.valid      = 1'b0;
    step_ch.a_row0     = '0;
    step_ch.a_row1     = '0;
    step_ch.a_row2     = '0;
    step_ch.a_row3     = '0;
    step_ch.b_col0     = '0;
    step_ch.b_col1     = '0;
    step_ch.b_col2     = '0;
    step_ch.b_col3     = '0;
    step_ch.first_step = 1'b0;
    step_ch.last_step  = 1'b0;
    res_ch.ready       = 1'b0;
    step_fire          = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    steps_pushed       = 0;
    steps_taken        = 0;
    tiles_drained      = 0;
    results_checked    = 0;
    fault_count        = 0;
    mismatch_count     = 0;
  end

  // golden accumulator update for one accepted k-step
  task automatic accumulate_kstep(input kstep_t s);
    otacc_pkg::elem_t av;
    otacc_pkg::elem_t bv;
    longint           total;
    tile_result_t     res;
    if (s.first) begin
      for (int r = 0; r < otacc_pkg::TILE_ROWS; r++)
        for (int c = 0; c < otacc_pkg::TILE_COLS; c++)
          tile_acc[r][c] = 0;
    end
    for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
      for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
        av = s.a[r];
        bv = s.b[c];
        total = tile_acc[r][c] + longint'(av) * longint'(bv);
        if (total > ACC_HI) total = ACC_HI;
        else if (total < ACC_LO) total = ACC_LO;
        tile_acc[r][c] = total;
      end
    end
    if (s.last) begin
      for (int r = 0; r < otacc_pkg::TILE_ROWS; r++) begin
        for (int c = 0; c < otacc_pkg::TILE_COLS; c++) begin
          res.row  = 2'(r);
          res.col  = 2'(c);
          res.sum  = otacc_pkg::acc_t'(tile_acc[r][c]);
          res.done = (r == otacc_pkg::TILE_ROWS - 1) && (c == otacc_pkg::TILE_COLS - 1);
          expected_sums.push_back(res);
        end
      end
      tiles_drained++;
    end
  endtask

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_result();
    tile_result_t want;
    if (expected_sums.size() == 0) begin
      report_fault($sformatf("unexpected result row %0d col %0d sum %0d done %0b",
                             res_ch.acc_row, res_ch.tile_col, res_ch.sum_value,
                             res_ch.tile_done));
      return;
    end
    want = expected_sums.pop_front();
    results_checked++;
    if (res_ch.acc_row !== want.row || res_ch.tile_col !== want.col ||
        res_ch.sum_value !== want.sum || res_ch.tile_done !== want.done) begin
      mismatch_count++;
      report_fault($sformatf("exp (%0d,%0d) %0d done %0b, got (%0d,%0d) %0d done %0b",
                             want.row, want.col, want.sum, want.done,
                             res_ch.acc_row, res_ch.tile_col, res_ch.sum_value,
                             res_ch.tile_done));
    end
  endtask

  // driver: a new transaction only once the current one has been taken
  always @(negedge clk) begin
    if (rst) begin
      step_ch.valid <= 1'b0;
    end else if (!step_ch.valid || step_fire) begin
      if (pending_ksteps.size() != 0 &&
          !(pending_ksteps[0].hold && expected_sums.size() != 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        drive_step = pending_ksteps.pop_front();
        step_ch.a_row0     <= drive_step.a[0];
        step_ch.a_row1     <= drive_step.a[1];
        step_ch.a_row2     <= drive_step.a[2];
        step_ch.a_row3     <= drive_step.a[3];
        step_ch.b_col0     <= drive_step.b[0];
        step_ch.b_col1     <= drive_step.b[1];
        step_ch.b_col2     <= drive_step.b[2];
        step_ch.b_col3     <= drive_step.b[3];
        step_ch.first_step <= drive_step.first;
        step_ch.last_step  <= drive_step.last;
        step_ch.valid      <= 1'b1;
      end else begin
        step_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: predict on accepted steps, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      step_fire <= 1'b0;
    end else begin
      step_fire <= step_ch.valid && step_ch.ready;
      if (step_ch.valid && step_ch.ready) begin
        taken_step.hold  = 1'b0;
        taken_step.first = step_ch.first_step;
        taken_step.last  = step_ch.last_step;
        taken_step.a     = {step_ch.a_row3, step_ch.a_row2, step_ch.a_row1, step_ch.a_row0};
        taken_step.b     = {step_ch.b_col3, step_ch.b_col2, step_ch.b_col1, step_ch.b_col0};
        accumulate_kstep(taken_step);
        steps_taken++;
      end
      if (res_ch.valid && res_ch.ready) check_result();
    end
  end

  function automatic otacc_pkg::elem_t rand_elem();
    case ($urandom_range(0, 7))
      0:       return otacc_pkg::elem_t'(16'h8000);
      1:       return otacc_pkg::elem_t'(16'h7fff);
      2:       return otacc_pkg::elem_t'(int'($urandom_range(0, 64)) - 32);
      default: return otacc_pkg::elem_t'($urandom);
    endcase
  endfunction

  task automatic queue_kstep(input logic [63:0] a, input logic [63:0] b,
                             input logic first, input logic last, input logic hold);
    kstep_t s;
    s.a     = a;
    s.b     = b;
    s.first = first;
    s.last  = last;
    s.hold  = hold;
    pending_ksteps.push_back(s);
    steps_pushed++;
  endtask

  task automatic queue_rand_kstep(input logic first, input logic last, input logic hold);
    queue_kstep({rand_elem(), rand_elem(), rand_elem(), rand_elem()},
                {rand_elem(), rand_elem(), rand_elem(), rand_elem()}, first, last, hold);
  endtask

  // mostly complete tiles, some stray steps and unterminated or headless tiles
  task automatic queue_random_phase(input int quota);
    int  count;
    int  depth;
    bit  hold;
    count = 0;
    hold  = 1'b1;
    while (count < quota) begin
      depth = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        7: begin
          queue_rand_kstep($urandom_range(0, 1), $urandom_range(0, 1), hold);
          depth = 1;
        end
        8: begin
          for (int i = 0; i < depth; i++)
            queue_rand_kstep(1'b0, i == depth - 1, hold && i == 0);
        end
        9: begin
          for (int i = 0; i < depth; i++)
            queue_rand_kstep(i == 0, 1'b0, hold && i == 0);
        end
        default: begin
          for (int i = 0; i < depth; i++)
            queue_rand_kstep(i == 0, i == depth - 1, hold && i == 0);
        end
      endcase
      count += depth;
      hold = ($urandom_range(0, 9) == 0);
    end
  endtask

  task automatic wait_all_taken();
    @(negedge clk);
    while (steps_taken != steps_pushed) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero tile, extreme products, drains with and without a clear
    queue_kstep('0, '0, 1'b1, 1'b1, 1'b0);
    queue_kstep({4{16'h8000}}, {4{16'h8000}}, 1'b1, 1'b0, 1'b0);
    queue_kstep({4{16'h7fff}}, {4{16'h8000}}, 1'b0, 1'b0, 1'b0);
    queue_kstep({16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                {16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 1'b0, 1'b1, 1'b0);
    queue_kstep('0, '0, 1'b0, 1'b1, 1'b1);
    queue_kstep({16'h0001, 16'hffff, 16'h7fff, 16'h8000},
                {16'hffff, 16'h0001, 16'h8000, 16'h7fff}, 1'b0, 1'b0, 1'b0);
    queue_kstep({4{16'h5555}}, {4{16'haaaa}}, 1'b0, 1'b1, 1'b0);
    queue_kstep({4{16'haaaa}}, {4{16'h5555}}, 1'b1, 1'b1, 1'b0);
    queue_kstep({4{16'hffff}}, {4{16'h0001}}, 1'b1, 1'b0, 1'b0);
    queue_kstep({4{16'h0001}}, {4{16'hffff}}, 1'b0, 1'b1, 1'b0);
    queue_kstep({4{16'h7fff}}, {4{16'h7fff}}, 1'b1, 1'b1, 1'b0);
    queue_kstep({16'h8000, 16'h0000, 16'h7fff, 16'h0001},
                {16'h0001, 16'h7fff, 16'h0000, 16'h8000}, 1'b1, 1'b1, 1'b1);
    wait_all_taken();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      queue_random_phase(PHASE_STEPS);
      wait_all_taken();
    end

    @(negedge clk);
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("run covered %0d k-step transactions, %0d tiles drained, %0d results checked",
             steps_taken, tiles_drained, results_checked);
    $display("under idle and stall phases; %0d field mismatches, %0d faults",
             mismatch_count, fault_count);
    if (fault_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

FILE: outer_product_tile_accumulator.f
rtl/otacc_pkg.sv
rtl/otacc_if.sv
rtl/otacc_ctrl.sv
rtl/otacc_dp.sv
rtl/outer_product_tile_accumulator.sv
rtl/otacc_chk.sv
bench/tb_top.sv
